/* sv/slid_pkg.sv */
// Package for the sorted list insert/delete core.
// Holds the sizes, item codes, controller states and controller/datapath structs.
// No dependencies.
`timescale 1ns / 1ps

package slid_pkg;

  // Store size and derived widths.
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Item kinds on the input channel.
  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_INSERTED  = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_DELETED   = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    CTL_IDLE   = 1'b0,
    CTL_RESULT = 1'b1
  } ctl_state_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic exec;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } dp_stat_t;

endpackage

/* sv/sorted_list_insert_delete_core.sv */
// Top level of the sorted list insert/delete core.
// Instantiates slid_ctrl and slid_datapath; depends on slid_pkg.
`timescale 1ns / 1ps

// Channel | direction | handshake              | payload
// input   | in        | in_valid_i / in_ready_o | kind_i, value_i
// output  | out       | out_valid_o / out_ready_i | status_o, removed_value_o,
//         |           |                        | entry_count_o, smallest_valid_o,
//         |           |                        | smallest_value_o
//
// Each item is executed in the cycle it is accepted: all 16 entries are
// compared in parallel and shift up or down by one place in that same edge.
// The result is presented on the following cycle and is held in a one-item
// output slot; a new item is taken while the slot is empty or being emptied,
// giving one item per cycle when the output is not stalled.
// Reset empties the store; entry contents are not cleared.

module sorted_list_insert_delete_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               kind_i,
  input  logic signed [slid_pkg::DATA_W-1:0] value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [slid_pkg::DATA_W-1:0] removed_value_o,
  output logic [slid_pkg::CNT_W-1:0]         entry_count_o,
  output logic                               smallest_valid_o,
  output logic signed [slid_pkg::DATA_W-1:0] smallest_value_o
);

  slid_pkg::ctl_cmd_t cmd;
  slid_pkg::dp_stat_t stat;

  // Handshake controller.
  slid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  // Entry store and result datapath.
  slid_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .kind_i           (kind_i),
    .value_i          (value_i),
    .status_o         (status_o),
    .removed_value_o  (removed_value_o),
    .entry_count_o    (entry_count_o),
    .smallest_valid_o (smallest_valid_o),
    .smallest_value_o (smallest_value_o)
  );

endmodule

/* sv/slid_datapath.sv */
// Datapath of the sorted list core: the row of stored entries, the count,
// the per-entry compares and the result registers. Depends on slid_pkg.
`timescale 1ns / 1ps

module slid_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  slid_pkg::ctl_cmd_t           cmd_i,
  output slid_pkg::dp_stat_t           stat_o,
  input  logic                         kind_i,
  input  logic signed [slid_pkg::DATA_W-1:0] value_i,
  output logic [1:0]                   status_o,
  output logic signed [slid_pkg::DATA_W-1:0] removed_value_o,
  output logic [slid_pkg::CNT_W-1:0]   entry_count_o,
  output logic                         smallest_valid_o,
  output logic signed [slid_pkg::DATA_W-1:0] smallest_value_o
);

  logic [slid_pkg::DATA_W-1:0] ent_q [slid_pkg::CAPACITY];
  logic [slid_pkg::DATA_W-1:0] ent_d [slid_pkg::CAPACITY];
  logic [slid_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  slid_pkg::status_e           status_q, status_d;
  logic [slid_pkg::DATA_W-1:0] removed_q, removed_d;

  logic [slid_pkg::CAPACITY-1:0] valid_vec;
  logic [slid_pkg::CAPACITY-1:0] lt_vec;
  logic [slid_pkg::CAPACITY-1:0] eq_vec;
  logic [slid_pkg::CAPACITY-1:0] first_eq;
  logic [slid_pkg::CAPACITY-1:0] before_eq;
  logic                          found;
  logic                          full;
  logic [slid_pkg::DATA_W-1:0]   val_key;

  // Flipping the sign bit makes an unsigned compare follow signed order.
  assign val_key = value_i ^ {1'b1, {(slid_pkg::DATA_W-1){1'b0}}};

  // Compare every stored entry with the item value in parallel.
  for (genvar g = 0; g < slid_pkg::CAPACITY; g++) begin : g_cmp
    logic [slid_pkg::DATA_W-1:0] ent_key;
    assign ent_key      = ent_q[g] ^ {1'b1, {(slid_pkg::DATA_W-1){1'b0}}};
    assign valid_vec[g] = (slid_pkg::CNT_W'(g) < cnt_q);
    assign lt_vec[g]    = valid_vec[g] && (ent_key < val_key);
    assign eq_vec[g]    = valid_vec[g] && (ent_q[g] == value_i);
  end

  // The first match is the lowest set bit; bits below it keep their entries.
  assign first_eq  = eq_vec & (~eq_vec + slid_pkg::CAPACITY'(1));
  assign before_eq = first_eq - slid_pkg::CAPACITY'(1);
  assign found     = |eq_vec;
  assign full      = (cnt_q >= slid_pkg::CNT_W'(slid_pkg::CAPACITY));

  // Next entries, count and result for the item being executed.
  always_comb begin
    for (int i = 0; i < slid_pkg::CAPACITY; i++) begin
      ent_d[i] = ent_q[i];
    end
    cnt_d     = cnt_q;
    status_d  = status_q;
    removed_d = removed_q;
    if (cmd_i.exec) begin
      removed_d = '0;
      if (kind_i == slid_pkg::KIND_INSERT) begin
        if (full) begin
          status_d = slid_pkg::STAT_FULL;
        end else begin
          status_d = slid_pkg::STAT_INSERTED;
          cnt_d    = cnt_q + slid_pkg::CNT_W'(1);
          // Entries at or after the insert point move up by one place.
          for (int i = 0; i < slid_pkg::CAPACITY; i++) begin
            if (!lt_vec[i]) begin
              if (i == 0) begin
                ent_d[i] = value_i;
              end else if (lt_vec[i-1]) begin
                ent_d[i] = value_i;
              end else begin
                ent_d[i] = ent_q[i-1];
              end
            end
          end
        end
      end else begin
        if (found) begin
          status_d  = slid_pkg::STAT_DELETED;
          removed_d = value_i;
          cnt_d     = cnt_q - slid_pkg::CNT_W'(1);
          // Entries from the first match on move down by one place.
          for (int i = 0; i < slid_pkg::CAPACITY - 1; i++) begin
            if (!before_eq[i]) begin
              ent_d[i] = ent_q[i+1];
            end
          end
        end else begin
          status_d = slid_pkg::STAT_NOT_FOUND;
        end
      end
    end
  end

  // Entry row and result registers: payload only, no reset.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < slid_pkg::CAPACITY; i++) begin
      ent_q[i] <= ent_d[i];
    end
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  // Entry count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The count and head change only when a result is issued, so they serve
  // the pending result directly.
  assign stat_o.count     = cnt_q;
  assign status_o         = status_q;
  assign removed_value_o  = removed_q;
  assign entry_count_o    = cnt_q;
  assign smallest_valid_o = (cnt_q != '0);
  assign smallest_value_o = (cnt_q != '0) ? ent_q[0] : '0;

endmodule

/* sv/slid_ctrl.sv */
// Controller of the sorted list core: handshake state machine that starts
// each item in the datapath and holds the result. Depends on slid_pkg.
`timescale 1ns / 1ps

module slid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output slid_pkg::ctl_cmd_t  cmd_o,
  input  slid_pkg::dp_stat_t  stat_i
);

  slid_pkg::ctl_state_e state_q, state_d;
  logic                 accept;

  assign accept = in_valid_i && in_ready_o;

  // Next state: a new item fills the result slot, a taken result frees it.
  always_comb begin
    state_d = state_q;
    case (state_q)
      slid_pkg::CTL_IDLE: begin
        if (accept) state_d = slid_pkg::CTL_RESULT;
      end
      slid_pkg::CTL_RESULT: begin
        if (accept) begin
          state_d = slid_pkg::CTL_RESULT;
        end else if (out_ready_i) begin
          state_d = slid_pkg::CTL_IDLE;
        end
      end
      default: state_d = slid_pkg::CTL_IDLE;
    endcase
  end

  // Outputs: the slot may be refilled in the cycle its result is taken.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      slid_pkg::CTL_IDLE: begin
        in_ready_o = 1'b1;
      end
      slid_pkg::CTL_RESULT: begin
        out_valid_o = 1'b1;
        in_ready_o  = out_ready_i;
      end
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.exec = accept;
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slid_pkg::CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // An accepted item always leaves a result pending.
  a_accept_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("no result after accepted item");

  // The entry count never exceeds the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.count <= slid_pkg::CNT_W'(slid_pkg::CAPACITY))
    else $error("entry count beyond capacity");

  // The count moves only when an item is executed.
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_o.exec |=> $stable(stat_i.count))
    else $error("entry count changed without an item");

  // A result waiting without being taken stays valid.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("pending result dropped");

endmodule
